[rtl/core/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the SPI ADC slave command unit.
// Concurrent assertions are written through these macros so that they can be
// compiled out as a group.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Clocked assertion that is switched off while reset is asserted.
`define SASCU_ASSERT(lbl, clk_s, rstn_s, prop, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) prop) else $error(msg);

// Clocked assertion that is checked on every edge, reset included.
`define SASCU_ASSERT_ALWAYS(lbl, clk_s, prop, msg) \
    lbl: assert property (@(posedge clk_s) prop) else $error(msg);

`else

`define SASCU_ASSERT(lbl, clk_s, rstn_s, prop, msg)
`define SASCU_ASSERT_ALWAYS(lbl, clk_s, prop, msg)

`endif

`endif

[rtl/core/sascu_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sascu_pkg
// Types, command codes and default sizes shared by the SPI ADC slave command
// unit and its channel interfaces.
// ----------------------------------------------------------------------------
package sascu_pkg;

    // Field widths fixed by the item formats.
    localparam int BYTE_W          = 8;
    localparam int SAMPLE_W        = 12;
    localparam int CHAN_W          = 4;
    localparam int SAMPLE_MAX_BITS = 16;

    // Default sizes of the converter.
    localparam int CHANNELS_DEF    = 12;
    localparam int SAMPLE_BITS_DEF = 12;

    // Command codes received from the SPI master.
    localparam logic [3:0]        GO_NIBBLE    = 4'h8;
    localparam logic [BYTE_W-1:0] PROBE_CODE   = 8'h40;
    localparam logic [BYTE_W-1:0] DATA_HI_CODE = 8'h90;
    localparam logic [BYTE_W-1:0] DATA_LO_CODE = 8'hA0;

    // Identity byte after reset.
    localparam logic [BYTE_W-1:0] ID_RESET = 8'h4C;

    // Kind of input item.
    typedef enum logic {
        ACT_CMD       = 1'b0,
        ACT_CONV_DONE = 1'b1
    } action_t;

endpackage

`default_nettype wire

[rtl/core/sascu_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sascu_if
// Valid/ready channels of the SPI ADC slave command unit: command input,
// result output and identity register write.
// ----------------------------------------------------------------------------

// Input items: SPI command bytes and conversion complete events.
interface sascu_cmd_if;
    import sascu_pkg::*;

    logic                valid;
    logic                ready;
    action_t             action;
    logic [BYTE_W-1:0]   rx_byte;
    logic [SAMPLE_W-1:0] sample;

    modport source (output valid, output action, output rx_byte, output sample,
                    input ready);
    modport sink   (input valid, input action, input rx_byte, input sample,
                    output ready);
endinterface

// Result items: transmit load, conversion control and status.
interface sascu_res_if;
    import sascu_pkg::*;

    logic              valid;
    logic              ready;
    logic              tx_load;
    logic [BYTE_W-1:0] tx_byte;
    logic              start_conv;
    logic              abort_conv;
    logic [CHAN_W-1:0] conv_channel;
    logic              busy_res;
    logic              data_ready;

    modport source (output valid, output tx_load, output tx_byte, output start_conv,
                    output abort_conv, output conv_channel, output busy_res,
                    output data_ready, input ready);
    modport sink   (input valid, input tx_load, input tx_byte, input start_conv,
                    input abort_conv, input conv_channel, input busy_res,
                    input data_ready, output ready);
endinterface

// Identity register write channel.
interface sascu_cfg_if;
    import sascu_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] identity_byte;

    modport source (output valid, output identity_byte, input ready);
    modport sink   (input valid, input identity_byte, output ready);
endinterface

`default_nettype wire

[rtl/core/spi_adc_slave_command_unit_top.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// spi_adc_slave_command_unit_top
// Slave side command decoder of an SPI linked ADC: decodes command bytes,
// controls conversions, keeps the last sample of each channel and picks the
// reply byte for the transmit buffer.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Carries
//  cmd      in         action, rx_byte, sample
//  res      out        tx_load, tx_byte, start_conv, abort_conv,
//                      conv_channel, busy_res, data_ready
//  cfg      in         identity_byte (always ready)
//
//  Each item passes through the input register and then the result register.
//  One item is accepted per cycle while the result side is not stalled.
//  Converter state and the sample store update as an item leaves the input
//  register, so the following item already sees them.
//  A stalled result holds both stages; cmd.ready drops only when both are full.
//  Reset clears the state and the sample store and sets the identity byte to 0x4C.
//
module spi_adc_slave_command_unit_top
    import sascu_pkg::*;
#(
    parameter int CHANNELS    = CHANNELS_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    sascu_cmd_if.sink  cmd,
    sascu_res_if.source res,
    sascu_cfg_if.sink  cfg
);

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // Identity register.
    logic [BYTE_W-1:0] id_reg;

    // Input register.
    logic                in_vld_reg;
    action_t             in_action_reg;
    logic [BYTE_W-1:0]   in_rx_reg;
    logic [SAMPLE_W-1:0] in_sample_reg;

    // Converter state.
    logic                   busy_reg;
    logic                   busy_next;
    logic [CHAN_W-1:0]      sel_reg;
    logic [CHAN_W-1:0]      sel_next;
    logic                   ready_reg;
    logic                   ready_next;
    logic [SAMPLE_BITS-1:0] store_reg [CHANNELS];

    // Result register.
    logic              out_vld_reg;
    logic              out_load_reg;
    logic [BYTE_W-1:0] out_tx_reg;
    logic              out_start_reg;
    logic              out_abort_reg;

    // Decode results.
    logic                       load_c;
    logic [BYTE_W-1:0]          tx_c;
    logic                       start_c;
    logic                       abort_c;
    logic                       store_wr_c;
    logic [CHAN_W-1:0]          go_chan;
    logic [SAMPLE_MAX_BITS-1:0] sample_ext;
    logic [SAMPLE_BITS-1:0]     sample_c;
    logic [SAMPLE_MAX_BITS-1:0] stored_ext;
    logic [IDX_W-1:0]           idx;

    // Handshake between the two stages.
    logic out_adv;
    logic fire;

    assign out_adv   = !out_vld_reg || res.ready;
    assign fire      = in_vld_reg && out_adv;
    assign cmd.ready = !in_vld_reg || out_adv;
    assign cfg.ready = 1'b1;

    // Identity register write.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            id_reg <= ID_RESET;
        end
        else if (cfg.valid)
        begin
            id_reg <= cfg.identity_byte;
        end
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (cmd.ready)
        begin
            in_vld_reg <= cmd.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.valid && cmd.ready)
        begin
            in_action_reg <= cmd.action;
            in_rx_reg     <= cmd.rx_byte;
            in_sample_reg <= cmd.sample;
        end
    end

    // Sample masking, store readback and go channel range check.
    assign sample_ext = SAMPLE_MAX_BITS'(in_sample_reg);
    assign sample_c   = sample_ext[SAMPLE_BITS-1:0];
    assign idx        = sel_reg[IDX_W-1:0];
    assign stored_ext = SAMPLE_MAX_BITS'(store_reg[idx]);
    assign go_chan    = ({1'b0, in_rx_reg[3:0]} < (CHAN_W + 1)'(CHANNELS))
                      ? in_rx_reg[3:0] : '0;

    // Command decode.
    always_comb
    begin
        load_c     = 1'b0;
        tx_c       = '0;
        start_c    = 1'b0;
        abort_c    = 1'b0;
        store_wr_c = 1'b0;
        busy_next  = busy_reg;
        sel_next   = sel_reg;
        ready_next = ready_reg;
        priority if (in_action_reg == ACT_CONV_DONE)
        begin
            // A completion while idle is ignored.
            if (busy_reg)
            begin
                store_wr_c = 1'b1;
                load_c     = 1'b1;
                tx_c       = sample_c[BYTE_W-1:0];
                ready_next = 1'b1;
                busy_next  = 1'b0;
            end
        end
        else if (in_rx_reg[7:4] == GO_NIBBLE)
        begin
            sel_next   = go_chan;
            ready_next = 1'b0;
            if (!busy_reg)
            begin
                busy_next = 1'b1;
                start_c   = 1'b1;
            end
            else
            begin
                busy_next = 1'b0;
                abort_c   = 1'b1;
                load_c    = 1'b1;
                tx_c      = id_reg;
            end
        end
        else if (in_rx_reg == PROBE_CODE)
        begin
            load_c = 1'b1;
            tx_c   = id_reg;
        end
        else if (in_rx_reg == DATA_HI_CODE || in_rx_reg == DATA_LO_CODE)
        begin
            load_c = 1'b1;
            priority if (busy_reg)
            begin
                tx_c = id_reg;
            end
            else if (in_rx_reg == DATA_HI_CODE)
            begin
                tx_c = stored_ext[15:8];
            end
            else
            begin
                tx_c = stored_ext[7:0];
            end
        end
        else
        begin
            // Unknown command bytes leave everything as it is.
            load_c = 1'b0;
        end
    end

    // Converter state update.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            sel_reg   <= '0;
            ready_reg <= 1'b0;
        end
        else if (fire)
        begin
            busy_reg  <= busy_next;
            sel_reg   <= sel_next;
            ready_reg <= ready_next;
        end
    end

    // Sample store, one entry per channel.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                store_reg[i] <= '0;
            end
        end
        else if (fire && store_wr_c)
        begin
            store_reg[idx] <= sample_c;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (out_adv)
        begin
            out_vld_reg <= in_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_load_reg  <= load_c;
            out_tx_reg    <= tx_c;
            out_start_reg <= start_c;
            out_abort_reg <= abort_c;
        end
    end

    // Status fields show the state left by the item in the result register.
    assign res.valid        = out_vld_reg;
    assign res.tx_load      = out_load_reg;
    assign res.tx_byte      = out_tx_reg;
    assign res.start_conv   = out_start_reg;
    assign res.abort_conv   = out_abort_reg;
    assign res.conv_channel = sel_reg;
    assign res.busy_res     = busy_reg;
    assign res.data_ready   = ready_reg;

    // A conversion is never running with data-ready still set.
    `SASCU_ASSERT_ALWAYS(a_busy_ready_excl, clk,
        (!rst_n || !(busy_reg && ready_reg)), "busy and data-ready both set")

    // The selected channel always addresses a real store entry.
    `SASCU_ASSERT_ALWAYS(a_sel_range, clk,
        (!rst_n || ({1'b0, sel_reg} < (CHAN_W + 1)'(CHANNELS))),
        "selected channel out of range")

    // A start leaves the converter busy with data-ready cleared.
    `SASCU_ASSERT(a_start_busy, clk, rst_n,
        (res.valid && res.start_conv) |-> (res.busy_res && !res.data_ready && !res.tx_load),
        "start without busy state")

    // An abort loads the identity byte and leaves the converter idle.
    `SASCU_ASSERT(a_abort_idle, clk, rst_n,
        (res.valid && res.abort_conv)
            |-> (res.tx_load && !res.busy_res && res.tx_byte == $past(id_reg)),
        "abort result inconsistent")

endmodule

`default_nettype wire

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SPI ADC slave command unit testbench
// Sends command bytes and conversion complete events through the command
// channel, rewrites the identity byte between phases, and checks every result
// item against a cycle-free model of the decoder kept inside the bench.
// ----------------------------------------------------------------------------
module testbench;
    import sascu_pkg::*;

    localparam int CHANNELS    = CHANNELS_DEF;
    localparam int QUIET_LIMIT = 1000;
    localparam int PHASES      = 9;
    localparam int PHASE_ITEMS = 100;

    // One command channel item.
    typedef struct packed {
        action_t             action;
        logic [BYTE_W-1:0]   rx_byte;
        logic [SAMPLE_W-1:0] sample;
    } cmd_item_t;

    // One result channel item.
    typedef struct packed {
        logic              tx_load;
        logic [BYTE_W-1:0] tx_byte;
        logic              start_conv;
        logic              abort_conv;
        logic [CHAN_W-1:0] conv_channel;
        logic              busy_res;
        logic              data_ready;
    } reply_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    // Values driven into the channels.
    logic              cmd_valid_q = 1'b0;
    cmd_item_t         cmd_item_q = '0;
    logic              res_rdy_q = 1'b0;
    logic              cfg_valid_q = 1'b0;
    logic [BYTE_W-1:0] cfg_data_q = '0;

    // Decoder model state.
    logic                       adc_busy = 1'b0;
    logic [CHAN_W-1:0]          sel_chan = '0;
    logic                       done_flag = 1'b0;
    logic [SAMPLE_MAX_BITS-1:0] sample_mem [CHANNELS];
    logic [BYTE_W-1:0]          id_byte = ID_RESET;

    cmd_item_t pending_cmds[$];
    reply_t    expected_replies[$];
    int        in_flight = 0;
    int        err_cnt = 0;
    int        quiet_cnt = 0;
    int        gap_cnt = 0;
    int        hold_cnt = 0;
    bit        pace_on = 1'b1;

    sascu_cmd_if cmd_ch ();
    sascu_res_if res_ch ();
    sascu_cfg_if cfg_ch ();

    assign cmd_ch.valid         = cmd_valid_q;
    assign cmd_ch.action        = cmd_item_q.action;
    assign cmd_ch.rx_byte       = cmd_item_q.rx_byte;
    assign cmd_ch.sample        = cmd_item_q.sample;
    assign res_ch.ready         = res_rdy_q;
    assign cfg_ch.valid         = cfg_valid_q;
    assign cfg_ch.identity_byte = cfg_data_q;

    spi_adc_slave_command_unit_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .res   (res_ch),
        .cfg   (cfg_ch)
    );

    // Free running clock, 4 ns period.
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Works out the reply to one command item and updates the model state.
    function automatic reply_t decode_cmd(cmd_item_t it);
        reply_t                     r;
        logic [CHAN_W-1:0]          ch;
        logic [SAMPLE_MAX_BITS-1:0] held;
        r = '0;
        held = (sel_chan < CHANNELS) ? sample_mem[sel_chan] : '0;
        if (it.action == ACT_CONV_DONE)
        begin
            // A finished conversion only counts while one is running.
            if (adc_busy)
            begin
                if (sel_chan < CHANNELS)
                    sample_mem[sel_chan] = SAMPLE_MAX_BITS'(it.sample);
                r.tx_load = 1'b1;
                r.tx_byte = it.sample[7:0];
                done_flag = 1'b1;
                adc_busy  = 1'b0;
            end
        end
        else if (it.rx_byte[7:4] == GO_NIBBLE)
        begin
            // Out of range channels fall back to channel zero.
            ch = it.rx_byte[3:0];
            if (ch >= CHANNELS)
                ch = '0;
            sel_chan  = ch;
            done_flag = 1'b0;
            if (!adc_busy)
            begin
                adc_busy     = 1'b1;
                r.start_conv = 1'b1;
            end
            else
            begin
                adc_busy     = 1'b0;
                r.abort_conv = 1'b1;
                r.tx_load    = 1'b1;
                r.tx_byte    = id_byte;
            end
        end
        else if (it.rx_byte == PROBE_CODE)
        begin
            r.tx_load = 1'b1;
            r.tx_byte = id_byte;
        end
        else if (it.rx_byte == DATA_HI_CODE || it.rx_byte == DATA_LO_CODE)
        begin
            r.tx_load = 1'b1;
            if (adc_busy)
                r.tx_byte = id_byte;
            else if (it.rx_byte == DATA_HI_CODE)
                r.tx_byte = held[15:8];
            else
                r.tx_byte = held[7:0];
        end
        r.conv_channel = sel_chan;
        r.busy_res     = adc_busy;
        r.data_ready   = done_flag;
        return r;
    endfunction

    // Random command item, mostly well formed commands.
    function automatic cmd_item_t random_cmd();
        cmd_item_t it;
        int        k;
        k = $urandom_range(0, 99);
        it.action  = ACT_CMD;
        it.rx_byte = BYTE_W'($urandom);
        it.sample  = SAMPLE_W'($urandom);
        if ($urandom_range(0, 7) == 0)
            it.sample = $urandom_range(0, 1) ? '1 : '0;
        if (k < 30)
            it.rx_byte = {GO_NIBBLE, 4'($urandom)};
        else if (k < 50)
            it.action = ACT_CONV_DONE;
        else if (k < 58)
            it.rx_byte = PROBE_CODE;
        else if (k < 82)
            it.rx_byte = $urandom_range(0, 1) ? DATA_HI_CODE : DATA_LO_CODE;
        else
            it.action = action_t'($urandom_range(0, 1));
        return it;
    endfunction

    task automatic send_cmd(logic [BYTE_W-1:0] code);
        cmd_item_t it;
        it.action  = ACT_CMD;
        it.rx_byte = code;
        it.sample  = SAMPLE_W'($urandom);
        pending_cmds.push_back(it);
        in_flight++;
    endtask

    task automatic send_done(logic [SAMPLE_W-1:0] value);
        cmd_item_t it;
        it.action  = ACT_CONV_DONE;
        it.rx_byte = BYTE_W'($urandom);
        it.sample  = value;
        pending_cmds.push_back(it);
        in_flight++;
    endtask

    // Waits until every queued item has produced its result.
    task automatic drain();
        while (in_flight != 0)
            @(posedge clk);
    endtask

    function automatic void compare_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            err_cnt++;
        end
    endfunction

    // Command driver: presents queued items with a random gap after each one while pacing is on.
    always @(posedge clk)
    begin : cmd_driver
        logic      live;
        cmd_item_t next_item;
        if (!rst_n)
        begin
            cmd_valid_q <= 1'b0;
            gap_cnt = 0;
        end
        else
        begin
            live = cmd_valid_q;
            next_item = cmd_item_q;
            if (cmd_valid_q && cmd_ch.ready)
            begin
                expected_replies.push_back(decode_cmd(cmd_item_q));
                live = 1'b0;
                gap_cnt = pace_on ? $urandom_range(0, 4) : 0;
            end
            if (!live)
            begin
                if (gap_cnt != 0)
                    gap_cnt--;
                else if (pending_cmds.size() != 0)
                begin
                    next_item = pending_cmds.pop_front();
                    live = 1'b1;
                end
            end
            cmd_valid_q <= live;
            cmd_item_q  <= next_item;
        end
    end

    // Result monitor: checks each result item and stalls at random after it while pacing is on.
    always @(posedge clk)
    begin : res_monitor
        reply_t want;
        if (!rst_n)
        begin
            res_rdy_q <= 1'b0;
            hold_cnt = 0;
        end
        else
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                if (expected_replies.size() == 0)
                begin
                    $error("result item arrived with nothing expected");
                    err_cnt++;
                end
                else
                begin
                    want = expected_replies.pop_front();
                    in_flight--;
                    compare_field("tx_load", want.tx_load, res_ch.tx_load);
                    compare_field("tx_byte", want.tx_byte, res_ch.tx_byte);
                    compare_field("start_conv", want.start_conv, res_ch.start_conv);
                    compare_field("abort_conv", want.abort_conv, res_ch.abort_conv);
                    compare_field("conv_channel", want.conv_channel, res_ch.conv_channel);
                    compare_field("busy_res", want.busy_res, res_ch.busy_res);
                    compare_field("data_ready", want.data_ready, res_ch.data_ready);
                end
                hold_cnt = pace_on ? $urandom_range(0, 4) : 0;
            end
            else if (hold_cnt != 0)
                hold_cnt--;
            res_rdy_q <= (hold_cnt == 0);
        end
    end

    // Watchdog on cycles without any accepted item.
    always @(posedge clk)
    begin
        if (!rst_n || (cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready))
            quiet_cnt <= 0;
        else if (quiet_cnt == QUIET_LIMIT)
        begin
            $display("spi_adc_slave_command_unit_top regression: fail");
            $finish;
        end
        else
            quiet_cnt <= quiet_cnt + 1;
    end

    // Stimulus: reset, a directed pass, then random phases with new identity bytes.
    initial
    begin
        logic [BYTE_W-1:0] new_id;
        foreach (sample_mem[i])
            sample_mem[i] = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Idle replies from reset state, ignored items, then full conversion cycles.
        send_cmd(PROBE_CODE);
        send_cmd(DATA_HI_CODE);
        send_cmd(DATA_LO_CODE);
        send_done('1);
        send_cmd(8'h00);
        send_cmd(8'hFF);
        send_cmd({GO_NIBBLE, 4'hB});
        send_cmd(DATA_HI_CODE);
        send_cmd(DATA_LO_CODE);
        send_done('1);
        send_cmd(DATA_HI_CODE);
        send_cmd(DATA_LO_CODE);
        send_cmd({GO_NIBBLE, 4'hC});
        send_cmd({GO_NIBBLE, 4'hF});
        send_cmd({GO_NIBBLE, 4'h0});
        send_done('0);
        send_cmd(DATA_LO_CODE);
        send_cmd({GO_NIBBLE, 4'h5});
        send_cmd({GO_NIBBLE, 4'h5});
        send_cmd(DATA_LO_CODE);
        send_cmd(PROBE_CODE);
        drain();

        for (int p = 0; p < PHASES; p++)
        begin
            // Identity byte write while the block is idle.
            case (p)
                0: new_id = '0;
                1: new_id = '1;
                2: new_id = ID_RESET;
                default: new_id = BYTE_W'($urandom);
            endcase
            pace_on = (p % 3) != 1;
            @(posedge clk);
            cfg_valid_q <= 1'b1;
            cfg_data_q  <= new_id;
            do
                @(posedge clk);
            while (!cfg_ch.ready);
            id_byte = new_id;
            cfg_valid_q <= 1'b0;

            repeat (PHASE_ITEMS)
            begin
                pending_cmds.push_back(random_cmd());
                in_flight++;
            end
            drain();
        end

        repeat (10) @(posedge clk);
        if (err_cnt == 0 && expected_replies.size() == 0)
            $display("spi_adc_slave_command_unit_top regression: pass");
        else
            $display("spi_adc_slave_command_unit_top regression: fail");
        $finish;
    end

endmodule
